[src/vtt_pkg.sv]
`timescale 1ns / 1ps

package vtt_pkg;

    // Fixed field widths of the stream payloads
    localparam int WORD_W      = 64;
    localparam int IN_WORDS    = 8;
    localparam int OP_W        = 2;
    localparam int VOTER_W     = 2;
    localparam int THR_W       = 2;
    localparam int COUNT_W     = 2;
    localparam int NUM_VOTERS  = 3;

    // s_tdata layout: opcode, voter, digest words 0..7, zero fill to 520 bits
    localparam int OPCODE_LSB  = 0;
    localparam int VOTER_LSB   = OPCODE_LSB + OP_W;
    localparam int DIGEST_LSB  = VOTER_LSB + VOTER_W;
    localparam int S_FIELDS_W  = DIGEST_LSB + IN_WORDS * WORD_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = 8;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int DIGEST_WORDS_DEF = 8;

    localparam logic [THR_W-1:0]   THR_RESET  = 2'd2;
    localparam logic [VOTER_W-1:0] VOTER_NONE = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SUBMIT = 2'd0,
        OP_CHECK  = 2'd1,
        OP_READ   = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ATTR_RD,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // Per-entry attributes, held in one memory word
    typedef struct packed {
        logic                  finalized;
        logic [COUNT_W-1:0]    count;
        logic [NUM_VOTERS-1:0] marks;
    } attr_t;

    // Result item; ok lands in bit 0
    typedef struct packed {
        logic [COUNT_W-1:0] total;
        logic               found;
        logic               agreed;
        logic               ok;
    } res_t;

endpackage

[src/vtt_ram.sv]
`timescale 1ns / 1ps

module vtt_ram
    import vtt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int WIDTH = WORD_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/vtt_ctrl.sv]
`timescale 1ns / 1ps

module vtt_ctrl
    import vtt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  op_t                                 op,
    input  logic [VOTER_W-1:0]                  voter,
    input  logic [DIGEST_WORDS*WORD_W-1:0]      key,
    input  logic [THR_W-1:0]                    threshold,
    input  logic [DIGEST_WORDS*WORD_W-1:0]      row_rdata,
    input  attr_t                               attr_rdata,
    input  logic                                out_free,
    output logic                                idle,
    output logic                                row_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]      row_raddr,
    output logic                                row_we,
    output logic                                attr_re,
    output logic                                attr_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      slot,
    output attr_t                               attr_wdata,
    output logic                                res_load,
    output res_t                                res
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    res_t             res_reg, res_next;

    logic                  issue;
    logic                  row_match;
    logic                  hit_now;
    logic                  search_end;
    logic                  room;
    attr_t                 base;
    attr_t                 upd;
    logic [NUM_VOTERS-1:0] mark_bit;

    // Shared compare unit: one stored row against the key per cycle
    assign row_match  = (row_rdata == key);
    assign issue      = (state_reg == ST_SEARCH) && (rd_idx_reg < used_reg);
    assign hit_now    = cmp_valid_reg && row_match;
    assign search_end = (state_reg == ST_SEARCH) && (hit_now || !issue);
    assign room       = (used_reg < FULL);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (search_end) begin
                    state_next = ST_ATTR_RD;
                end
            end
            ST_ATTR_RD: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_idx_next    = rd_idx_reg;
        used_next      = used_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        row_we         = 1'b0;
        attr_we        = 1'b0;
        base           = hit_reg ? attr_rdata : '0;
        upd            = base;
        mark_bit       = NUM_VOTERS'(1) << voter;

        if (start && state_reg == ST_IDLE) begin
            rd_idx_next = '0;
        end

        if (state_reg == ST_SEARCH) begin
            if (issue) begin
                rd_idx_next    = rd_idx_reg + CNT_W'(1);
                cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                cmp_valid_next = !hit_now;
            end
            if (search_end) begin
                hit_next  = hit_now;
                slot_next = hit_now ? cmp_idx_reg : used_reg[IDX_W-1:0];
            end
        end

        if (state_reg == ST_UPDATE) begin
            res_next.ok     = 1'b0;
            res_next.agreed = 1'b0;
            res_next.found  = hit_reg && (op != OP_UNUSED);
            res_next.total  = res_next.found ? base.count : '0;
            case (op)
                OP_SUBMIT: begin
                    if (voter != VOTER_NONE && (hit_reg || room)) begin
                        if ((base.marks & mark_bit) == '0) begin
                            upd.marks = base.marks | mark_bit;
                            upd.count = COUNT_W'(base.count + COUNT_W'(1));
                        end
                        attr_we        = 1'b1;
                        row_we         = !hit_reg;
                        used_next      = hit_reg ? used_reg : used_reg + CNT_W'(1);
                        res_next.ok    = 1'b1;
                        res_next.total = upd.count;
                    end
                end
                OP_CHECK: begin
                    if (hit_reg && (base.finalized || base.count >= threshold)) begin
                        upd.finalized   = 1'b1;
                        attr_we         = 1'b1;
                        res_next.agreed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign idle       = (state_reg == ST_IDLE);
    assign row_re     = issue;
    assign row_raddr  = rd_idx_reg[IDX_W-1:0];
    assign attr_re    = (state_reg == ST_ATTR_RD);
    assign slot       = slot_reg;
    assign attr_wdata = upd;
    assign res_load   = (state_reg == ST_DONE) && out_free;
    assign res        = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            cmp_valid_reg <= cmp_valid_next;
            rd_idx_reg    <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        res_reg     <= res_next;
    end

endmodule

[src/vote_tally_table_unit.sv]
`timescale 1ns / 1ps

// Vote tally table. Keeps up to TABLE_DEPTH digests of DIGEST_WORDS 64-bit
// words in arrival order, each with voter marks, a 2-bit vote count and a
// finalized flag. Every transfer on the s_ side (submit, check, read count)
// first scans the stored digests one row per cycle through a single
// full-width compare unit fed by the digest memory, stopping at the first
// match. s_tready drops after a transfer and stays low through the scan,
// the attribute read and update, and any wait for the m_ output register
// to drain; an early match ends the scan sooner. The block takes one item
// at a time, but a finished result sits in the m_ output register and the
// next item is accepted while it waits. The threshold must be written over
// the cfg_ channel (reset value 2) only while no item is in flight; the
// block itself does not enforce it. Memories carry no reset: an entry is
// always fully written when appended.
module vote_tally_table_unit
    import vtt_pkg::*;
#(
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int DIGEST_WORDS = DIGEST_WORDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // opcode[1:0], voter[3:2], digest_word0..7 [67:4]..[515:452], zero fill
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0], agreed[1], found[2], vote_total[4:3], zero fill
    output logic [M_TDATA_W-1:0] m_tdata,
    // Threshold register write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [THR_W-1:0]     cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int ROW_W  = DIGEST_WORDS * WORD_W;
    localparam int ATTR_W = $bits(attr_t);

    logic [THR_W-1:0]   thr_reg;
    op_t                op_reg;
    logic [VOTER_W-1:0] voter_reg;
    logic [ROW_W-1:0]   key_reg, key_next;
    logic               m_valid_reg;
    res_t               m_res_reg;

    logic             s_xfer;
    logic             out_free;
    logic             idle;
    logic             row_re;
    logic [IDX_W-1:0] row_raddr;
    logic             row_we;
    logic [ROW_W-1:0] row_rdata;
    logic             attr_re;
    logic             attr_we;
    logic [IDX_W-1:0] slot;
    attr_t            attr_wdata;
    attr_t            attr_rdata;
    logic             res_load;
    res_t             res;

    assign s_tready  = idle;
    assign s_xfer    = s_tvalid && idle;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // Pick out the digest words that take part in the match
    always_comb begin
        for (int w = 0; w < DIGEST_WORDS; w++) begin
            key_next[w*WORD_W +: WORD_W] = s_tdata[DIGEST_LSB + w*WORD_W +: WORD_W];
        end
    end

    // Hold the item for the whole scan
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            op_reg    <= op_t'(s_tdata[OPCODE_LSB +: OP_W]);
            voter_reg <= s_tdata[VOTER_LSB +: VOTER_W];
            key_reg   <= key_next;
        end
    end

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_reg <= cfg_data;
        end
    end

    // Output register: load when empty or being drained, drop on transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, m_res_reg};

    // Digest rows, one full digest per word
    vtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ROW_W)
    ) u_digest_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (slot),
        .wdata (key_reg),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // Voter marks, count and finalized flag per entry
    vtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ATTR_W)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (slot),
        .wdata (attr_wdata),
        .re    (attr_re),
        .raddr (slot),
        .rdata (attr_rdata)
    );

    vtt_ctrl #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .DIGEST_WORDS (DIGEST_WORDS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_xfer),
        .op         (op_reg),
        .voter      (voter_reg),
        .key        (key_reg),
        .threshold  (thr_reg),
        .row_rdata  (row_rdata),
        .attr_rdata (attr_rdata),
        .out_free   (out_free),
        .idle       (idle),
        .row_re     (row_re),
        .row_raddr  (row_raddr),
        .row_we     (row_we),
        .attr_re    (attr_re),
        .attr_we    (attr_we),
        .slot       (slot),
        .attr_wdata (attr_wdata),
        .res_load   (res_load),
        .res        (res)
    );

`ifndef NO_ASSERTIONS
    // An accepted item keeps the block busy for at least the scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> !s_tready)
        else $error("input taken again right after a transfer");

    // A new result never overwrites one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // Agreement needs a present entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.agreed |-> m_res_reg.found)
        else $error("agreed without a matching entry");

    // An accepted submit always leaves a nonzero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_res_reg.ok |-> (m_res_reg.total != '0))
        else $error("accepted submit with zero count");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import vtt_pkg::*;

    localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
    localparam int DIGEST_W     = IN_WORDS * WORD_W;
    localparam int PAD_W        = S_TDATA_W - S_FIELDS_W;
    localparam int STALL_LIMIT  = 20000;  // well above one full scan plus the long hold-off
    localparam int HOLD_CYCLES  = 1500;
    localparam int HOLD_AT      = 60;
    localparam int REPORT_MAX   = 10;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic [DIGEST_W-1:0] digest;
        logic [VOTER_W-1:0]  voter;
        op_t                 op;
    } vote_req_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [THR_W-1:0]     cfg_data  = '0;

    vote_tally_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .DIGEST_WORDS(IN_WORDS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow of the tally table
    logic [DIGEST_W-1:0]   tbl_digest [TABLE_DEPTH];
    logic [NUM_VOTERS-1:0] tbl_marks  [TABLE_DEPTH];
    logic [COUNT_W-1:0]    tbl_count  [TABLE_DEPTH];
    logic                  tbl_final  [TABLE_DEPTH];
    int                    entry_count = 0;
    logic [THR_W-1:0]      threshold   = THR_RESET;

    vote_req_t           vote_queue [$];
    res_t                outcome_q  [$];
    logic [DIGEST_W-1:0] digest_pool [$];

    int src_idle_pct = 32;
    int snk_idle_pct = 32;
    int mismatches   = 0;
    int stall_cycles = 0;

    // Look the digest up, apply the operation to the shadow table, return the outcome.
    function automatic res_t tally_outcome(vote_req_t r);
        res_t o;
        int   slot;
        o    = '0;
        slot = -1;
        for (int i = 0; i < entry_count && slot < 0; i++) begin
            if (tbl_digest[i] == r.digest) slot = i;
        end
        if (r.op != OP_UNUSED && slot >= 0) begin
            o.found = 1'b1;
            o.total = tbl_count[slot];
        end
        case (r.op)
            OP_SUBMIT: begin
                if (r.voter != VOTER_NONE) begin
                    // append an absent digest while there is room
                    if (slot < 0 && entry_count < TABLE_DEPTH) begin
                        slot             = entry_count;
                        tbl_digest[slot] = r.digest;
                        tbl_marks[slot]  = '0;
                        tbl_count[slot]  = '0;
                        tbl_final[slot]  = 1'b0;
                        entry_count++;
                    end
                    if (slot >= 0) begin
                        // count each voter once
                        if (!tbl_marks[slot][r.voter]) begin
                            tbl_marks[slot][r.voter] = 1'b1;
                            tbl_count[slot]          = tbl_count[slot] + 1'b1;
                        end
                        o.ok    = 1'b1;
                        o.total = tbl_count[slot];
                    end
                end
            end
            OP_CHECK: begin
                if (slot >= 0 && (tbl_final[slot] || tbl_count[slot] >= threshold)) begin
                    tbl_final[slot] = 1'b1;
                    o.agreed        = 1'b1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [DIGEST_W-1:0] rand_digest();
        logic [DIGEST_W-1:0] d;
        for (int i = 0; i < DIGEST_W / 32; i++) d[i*32 +: 32] = $urandom;
        return d;
    endfunction

    // Mostly votes on known digests, chiefly recent ones, so that entries get
    // driven to agreement; the rest are near misses and fresh digests.
    function automatic vote_req_t random_vote();
        vote_req_t r;
        int        roll;
        int        n;
        int        span;
        int        pick;
        bit        fresh;
        roll    = int'($urandom_range(0, 99));
        r.op    = roll < 50 ? OP_SUBMIT : roll < 75 ? OP_CHECK : roll < 95 ? OP_READ : OP_UNUSED;
        r.voter = ($urandom_range(0, 99) < 8) ? VOTER_NONE : VOTER_W'($urandom_range(0, 2));
        n       = digest_pool.size();
        roll    = int'($urandom_range(0, 99));
        fresh   = (n == 0 || roll >= 70);
        if (n == 0 || roll >= 85) begin
            r.digest = rand_digest();
        end else begin
            span = n < 8 ? n : 8;
            if ($urandom_range(0, 99) < 70) pick = n - 1 - int'($urandom_range(0, span - 1));
            else pick = int'($urandom_range(0, n - 1));
            r.digest = digest_pool[pick];
            if (roll >= 70) begin
                // near miss: one bit off a known digest
                pick           = int'($urandom_range(0, DIGEST_W - 1));
                r.digest[pick] = ~r.digest[pick];
            end
        end
        if (fresh && r.op == OP_SUBMIT && r.voter != VOTER_NONE) digest_pool.push_back(r.digest);
        return r;
    endfunction

    task automatic push_vote(op_t op, logic [VOTER_W-1:0] voter, logic [DIGEST_W-1:0] digest);
        vote_req_t r;
        r.op     = op;
        r.voter  = voter;
        r.digest = digest;
        vote_queue.push_back(r);
    endtask

    task automatic push_random(int n);
        repeat (n) vote_queue.push_back(random_vote());
    endtask

    // Wait until every item is transferred and every outcome has come back.
    task automatic drain();
        do @(negedge aclk);
        while (vote_queue.size() != 0 || s_tvalid || outcome_q.size() != 0);
    endtask

    task automatic set_threshold(logic [THR_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Input driver: advance on a transfer, idle at random between items.
    always @(posedge aclk) begin
        vote_req_t next_vote;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (vote_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                next_vote = vote_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {{PAD_W{1'b0}}, next_vote.digest, next_vote.voter, next_vote.op};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: stall at random; hold off once for a long stretch so the
    // block backs up and drops s_tready while items keep coming.
    int results_taken = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) results_taken <= results_taken + 1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (!hold_done && results_taken >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // Monitor: track threshold writes, predict on each input transfer,
    // compare each output transfer with the oldest outcome.
    always @(posedge aclk) begin
        vote_req_t r;
        res_t      got;
        res_t      want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) threshold = cfg_data;
            if (s_tvalid && s_tready) begin
                r.op     = op_t'(s_tdata[OPCODE_LSB +: OP_W]);
                r.voter  = s_tdata[VOTER_LSB +: VOTER_W];
                r.digest = s_tdata[DIGEST_LSB +: DIGEST_W];
                outcome_q.push_back(tally_outcome(r));
            end
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[$bits(res_t)-1:0]);
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("tb: unexpected result ok=%0d agreed=%0d found=%0d total=%0d",
                                 got.ok, got.agreed, got.found, got.total);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.ok != want.ok || got.agreed != want.agreed ||
                        got.found != want.found || got.total != want.total) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX) begin
                            $write("tb: mismatch at %0t: expected ok=%0d agreed=%0d found=%0d",
                                   $time, want.ok, want.agreed, want.found);
                            $display(" total=%0d, actual ok=%0d agreed=%0d found=%0d total=%0d",
                                     want.total, got.ok, got.agreed, got.found, got.total);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding and no transfer anywhere.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) ||
            (vote_queue.size() == 0 && !s_tvalid && outcome_q.size() == 0 && !cfg_valid)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [DIGEST_W-1:0] d_zero;
        logic [DIGEST_W-1:0] d_ones;
        logic [DIGEST_W-1:0] d_mix;
        d_zero = '0;
        d_ones = '1;
        d_mix  = rand_digest();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset threshold of two
        push_vote(OP_READ,   2'd0,       d_zero);  // absent
        push_vote(OP_CHECK,  2'd0,       d_zero);  // absent
        push_vote(OP_SUBMIT, 2'd0,       d_zero);  // append
        push_vote(OP_SUBMIT, 2'd0,       d_zero);  // repeated voter
        push_vote(OP_CHECK,  2'd1,       d_zero);  // below threshold
        push_vote(OP_SUBMIT, VOTER_NONE, d_zero);  // invalid voter, present
        push_vote(OP_SUBMIT, VOTER_NONE, d_ones);  // invalid voter, absent
        push_vote(OP_READ,   2'd2,       d_ones);
        push_vote(OP_SUBMIT, 2'd1,       d_zero);
        push_vote(OP_CHECK,  2'd0,       d_zero);  // reaches threshold, finalize
        push_vote(OP_SUBMIT, 2'd2,       d_zero);
        push_vote(OP_READ,   2'd0,       d_zero);
        push_vote(OP_UNUSED, VOTER_NONE, d_zero);
        push_vote(OP_SUBMIT, 2'd2,       d_ones);
        push_vote(OP_CHECK,  2'd1,       d_ones);
        drain();

        set_threshold(2'd0);
        push_vote(OP_CHECK,  2'd0, d_ones);        // zero threshold agrees
        push_vote(OP_CHECK,  2'd0, d_mix);         // absent
        push_vote(OP_READ,   2'd3, d_mix);
        drain();

        set_threshold(2'd3);
        push_vote(OP_SUBMIT, 2'd1, d_mix);
        push_vote(OP_SUBMIT, 2'd0, d_mix);
        push_vote(OP_CHECK,  2'd0, d_mix);         // two of three, no agreement
        push_vote(OP_SUBMIT, 2'd2, d_mix);
        push_vote(OP_CHECK,  2'd0, d_mix);
        push_vote(OP_CHECK,  2'd0, d_ones);        // already finalized, count below
        push_vote(OP_UNUSED, 2'd1, d_ones);
        drain();
        digest_pool.push_back(d_zero);
        digest_pool.push_back(d_ones);
        digest_pool.push_back(d_mix);

        // Random votes, then a stretch with no idling on either side
        set_threshold(2'd1);
        push_random(100);
        drain();

        set_threshold(2'd3);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        push_random(100);
        drain();
        src_idle_pct = 32;
        snk_idle_pct = 32;

        // Fill the table with fresh digests
        set_threshold(2'd2);
        while (entry_count < TABLE_DEPTH) begin
            repeat (TABLE_DEPTH - entry_count) begin
                d_mix = rand_digest();
                digest_pool.push_back(d_mix);
                push_vote(OP_SUBMIT, VOTER_W'($urandom_range(0, 2)), d_mix);
            end
            drain();
        end

        // Full table: fresh digests are refused, stored ones still vote
        set_threshold(2'd1);
        push_random(150);
        drain();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
